// ===== rtl/rwsd_pkg.sv =====
package rwsd_pkg;

    // Field widths fixed by the beat formats.
    localparam int SAMPLE_BITS = 24;
    localparam int STD_BITS    = 24;

    // Configuration port.
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOF_CORRECTION = 2'd1;

    localparam int               WIN_RESET = 20;
    localparam logic [CFG_W-1:0] DOF_RESET = 9'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_ok;
    } t_in_beat;

    typedef struct packed {
        logic [STD_BITS-1:0] std_value;
        logic                std_ok;
    } t_out_beat;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ===== rtl/rwsd_ring.sv =====
module rwsd_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read and write share one address; the read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rwsd_alu.sv =====
module rwsd_alu #(
    parameter int WIDTH = 66
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  rwsd_pkg::t_alu_op i_op,
    output logic [WIDTH-1:0] o_res,
    output logic             o_carry
);

    import rwsd_pkg::*;

    logic             is_sub;
    logic [WIDTH-1:0] b_in;
    logic [WIDTH:0]   sum_ext;

    // On a subtract the carry out is set when a >= b (unsigned).
    assign is_sub  = (i_op == ALU_SUB);
    assign b_in    = is_sub ? ~i_b : i_b;
    assign sum_ext = {1'b0, i_a} + {1'b0, b_in} + {{WIDTH{1'b0}}, is_sub};
    assign o_res   = sum_ext[WIDTH-1:0];
    assign o_carry = sum_ext[WIDTH];

endmodule

// ===== rtl/rolling_window_std_deviation_unit.sv =====
// Sliding-window standard deviation over signed fixed-point samples.
//
// Input beats (i_valid / o_stall) carry one sample and a flag that marks it
// as a number or as missing. Each accepted beat yields exactly one output
// beat (o_valid / i_stall) with the floor of the window's standard
// deviation, saturated to 24 bits, and a flag that is low while the window
// is not yet full, while a missing sample lies in it, or when the window
// length does not exceed the degrees-of-freedom correction.
//
// One sample is worked at a time. The sums, products, divide and root run
// on a single shared adder under a small sequencer: the two sample squares
// and the three window products are shift-and-add multiplies, the variance
// is a restoring divide with 2*SAMPLE_BITS+1 quotient steps, and the root
// is a digit-by-digit integer square root of SAMPLE_BITS steps. o_stall
// stays high for the whole computation, so the next beat can be taken no
// earlier than the cycle after the result is written.
//
// Reset clears the window and loads a window length of 20 and a correction
// of 1. A finished beat waits in the output register while the receiver
// stalls; the next sample is still accepted meanwhile, and a second result
// waits in the sequencer until the first one has been taken.
module rolling_window_std_deviation_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  rwsd_pkg::t_in_beat                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output rwsd_pkg::t_out_beat                 o_data,
    input  logic                                i_cfg_we,
    input  logic [rwsd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rwsd_pkg::CFG_W-1:0]          i_cfg_data
);

    import rwsd_pkg::*;

    // Widths that follow from the window depth and the sample width.
    localparam int SB        = SAMPLE_BITS;
    localparam int AW        = $clog2(MAX_WINDOW + 1);
    localparam int PW        = $clog2(MAX_WINDOW);
    localparam int SUM_W     = SB + AW;
    localparam int SQ_W      = 2 * SB - 2 + AW;
    localparam int QB        = 2 * SB;
    localparam int DW        = 2 * SB + 2 * AW;
    localparam int CW        = (AW > CFG_W) ? AW : CFG_W;
    localparam int STEPS_MAX = (SUM_W > QB + 1) ? SUM_W : QB + 1;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    localparam logic [AW-1:0] RST_WIN =
        AW'((WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET);
    localparam logic [CW-1:0] MAXW_C  = CW'(MAX_WINDOW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_NEW,
        S_MUL,
        S_STORE,
        S_DEN,
        S_SQS1,
        S_DIVINIT,
        S_DIV,
        S_ROOTINIT,
        S_ROOT,
        S_DONE
    } t_state;

    // Sequencer and window state.
    t_state                   r_state;
    t_state                   r_ret;
    logic [AW-1:0]            r_w;
    logic [CFG_W-1:0]         r_ddof;
    logic [PW-1:0]            r_ptr;
    logic [AW-1:0]            r_fill;
    logic [AW-1:0]            r_miss;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]          r_sq;

    // Working registers of the current sample.
    logic signed [SB-1:0]     r_smp;
    logic                     r_ok;
    logic                     r_full;
    logic [DW-1:0]            r_acc;
    logic [DW-1:0]            r_mcand;
    logic [SUM_W-1:0]         r_mplier;
    t_alu_op                  r_mul_op;
    logic [CNT_W-1:0]         r_cnt;
    logic [2*AW-1:0]          r_den;
    logic [QB:0]              r_q;
    logic [QB-1:0]            r_root;
    logic [QB-1:0]            r_bit;
    logic                     r_res_ok;

    logic                     r_out_valid;
    t_out_beat                r_out;

    // Combinational helpers.
    logic                     accept;
    logic [CW-1:0]            cfg_ext;
    logic [AW-1:0]            cfg_w_eff;
    logic [SB:0]              ring_rdata;
    logic signed [SB-1:0]     old_s;
    logic                     old_ok;
    logic [SB-1:0]            old_u;
    logic [SB-1:0]            old_mag;
    logic [SB-1:0]            new_u;
    logic [SB-1:0]            new_mag;
    logic [SUM_W-1:0]         sum_u;
    logic [SUM_W-1:0]         sum_mag;
    logic [CW-1:0]            w_ext;
    logic [CW-1:0]            ddof_ext;
    logic                     win_ok;
    logic [AW-1:0]            w_minus_d;
    logic [AW-1:0]            ptr_inc;
    logic [PW-1:0]            ptr_next;
    logic                     res_valid;
    logic [DW-1:0]            alu_a;
    logic [DW-1:0]            alu_b;
    t_alu_op                  alu_op;
    logic [DW-1:0]            alu_res;
    logic                     alu_carry;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A window length of zero acts as one; anything above the ring depth
    // acts as the ring depth.
    assign cfg_ext   = CW'(i_cfg_data);
    assign cfg_w_eff = (cfg_ext == '0)    ? AW'(1) :
                       (cfg_ext > MAXW_C) ? AW'(MAXW_C) : AW'(cfg_ext);

    assign old_s   = ring_rdata[SB-1:0];
    assign old_ok  = ring_rdata[SB];
    assign old_u   = ring_rdata[SB-1:0];
    assign old_mag = old_u[SB-1] ? (~old_u + SB'(1)) : old_u;
    assign new_u   = r_smp;
    assign new_mag = new_u[SB-1] ? (~new_u + SB'(1)) : new_u;
    assign sum_u   = r_sum;
    assign sum_mag = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;

    assign w_ext     = CW'(r_w);
    assign ddof_ext  = CW'(r_ddof);
    assign win_ok    = (w_ext > ddof_ext);
    assign w_minus_d = AW'(w_ext - ddof_ext);

    // The ring pointer wraps at the current window length.
    assign ptr_inc  = AW'(r_ptr) + AW'(1);
    assign ptr_next = (ptr_inc == r_w) ? '0 : PW'(ptr_inc);

    assign res_valid = (r_fill == r_w) && (r_miss == '0) && win_ok;

    // Operand selection for the shared adder.
    always_comb begin
        alu_a  = r_acc;
        alu_b  = '0;
        alu_op = ALU_ADD;
        case (r_state)
            S_FETCH: begin
                alu_a  = DW'(r_sum);
                alu_b  = DW'(old_s);
                alu_op = ALU_SUB;
            end
            S_NEW: begin
                alu_a  = DW'(r_sum);
                alu_b  = DW'(r_smp);
                alu_op = ALU_ADD;
            end
            S_MUL: begin
                alu_b  = r_mplier[0] ? r_mcand : '0;
                alu_op = r_mul_op;
            end
            S_DIV: begin
                alu_b  = r_mcand;
                alu_op = ALU_SUB;
            end
            S_ROOT: begin
                alu_b  = DW'(r_root | r_bit);
                alu_op = ALU_SUB;
            end
            default: begin
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    rwsd_alu #(
        .WIDTH(DW)
    ) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_op   (alu_op),
        .o_res  (alu_res),
        .o_carry(alu_carry)
    );

    // The new sample is written into the slot whose old contents are read
    // out in the same cycle.
    rwsd_ring #(
        .DEPTH(MAX_WINDOW),
        .WIDTH(SB + 1)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_addr (r_ptr),
        .i_wdata({i_data.sample_ok, i_data.sample}),
        .o_rdata(ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w         <= RST_WIN;
            r_ddof      <= DOF_RESET;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_miss      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
        end else begin
            // In the finishing state the output register is handled below.
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            // A new window length restarts the fill of the window.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LENGTH: begin
                        r_w    <= cfg_w_eff;
                        r_ptr  <= '0;
                        r_fill <= '0;
                        r_miss <= '0;
                        r_sum  <= '0;
                        r_sq   <= '0;
                    end
                    REG_DOF_CORRECTION: begin
                        r_ddof <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_smp  <= i_data.sample;
                        r_ok   <= i_data.sample_ok;
                        r_full <= (r_fill == r_w);
                        if (r_fill != r_w) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_ptr   <= ptr_next;
                        r_state <= S_FETCH;
                    end
                end
                // Retire the sample that leaves the window.
                S_FETCH: begin
                    r_acc <= DW'(r_sq);
                    if (r_full && old_ok) begin
                        r_sum    <= alu_res[SUM_W-1:0];
                        r_mcand  <= DW'(old_mag);
                        r_mplier <= SUM_W'(old_mag);
                        r_cnt    <= CNT_W'(SB);
                        r_mul_op <= ALU_SUB;
                        r_ret    <= S_NEW;
                        r_state  <= S_MUL;
                    end else begin
                        if (r_full && r_miss != '0) begin
                            r_miss <= r_miss - 1'b1;
                        end
                        r_state <= S_NEW;
                    end
                end
                // Add the sample that enters the window.
                S_NEW: begin
                    if (r_ok) begin
                        r_sum    <= alu_res[SUM_W-1:0];
                        r_mcand  <= DW'(new_mag);
                        r_mplier <= SUM_W'(new_mag);
                        r_cnt    <= CNT_W'(SB);
                        r_mul_op <= ALU_ADD;
                        r_ret    <= S_STORE;
                        r_state  <= S_MUL;
                    end else begin
                        r_miss  <= r_miss + 1'b1;
                        r_state <= S_STORE;
                    end
                end
                // One shift-and-add step; the accumulator gains or loses
                // one partial product.
                S_MUL: begin
                    r_acc    <= alu_res;
                    r_mcand  <= {r_mcand[DW-2:0], 1'b0};
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= r_ret;
                    end
                end
                S_STORE: begin
                    r_sq <= r_acc[SQ_W-1:0];
                    if (res_valid) begin
                        r_res_ok <= 1'b1;
                        r_acc    <= '0;
                        r_mcand  <= DW'(r_w);
                        r_mplier <= SUM_W'(w_minus_d);
                        r_cnt    <= CNT_W'(AW);
                        r_mul_op <= ALU_ADD;
                        r_ret    <= S_DEN;
                        r_state  <= S_MUL;
                    end else begin
                        r_res_ok <= 1'b0;
                        r_root   <= '0;
                        r_state  <= S_DONE;
                    end
                end
                // Divisor is ready; start the numerator with w times S2.
                S_DEN: begin
                    r_den    <= r_acc[2*AW-1:0];
                    r_acc    <= '0;
                    r_mcand  <= DW'(r_sq);
                    r_mplier <= SUM_W'(r_w);
                    r_cnt    <= CNT_W'(AW);
                    r_mul_op <= ALU_ADD;
                    r_ret    <= S_SQS1;
                    r_state  <= S_MUL;
                end
                // Take the square of the sum off the numerator.
                S_SQS1: begin
                    r_mcand  <= DW'(sum_mag);
                    r_mplier <= sum_mag;
                    r_cnt    <= CNT_W'(SUM_W);
                    r_mul_op <= ALU_SUB;
                    r_ret    <= S_DIVINIT;
                    r_state  <= S_MUL;
                end
                S_DIVINIT: begin
                    r_mcand <= DW'(r_den) << QB;
                    r_q     <= '0;
                    r_cnt   <= CNT_W'(QB + 1);
                    r_state <= S_DIV;
                end
                // Restoring divide, one quotient bit per cycle. The top bit
                // only flags a quotient too large for the output.
                S_DIV: begin
                    if (alu_carry) begin
                        r_acc <= alu_res;
                    end
                    r_q     <= {r_q[QB-1:0], alu_carry};
                    r_mcand <= r_mcand >> 1;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_ROOTINIT;
                    end
                end
                S_ROOTINIT: begin
                    if (r_q[QB]) begin
                        r_root  <= '1;
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= DW'(r_q[QB-1:0]);
                        r_root  <= '0;
                        r_bit   <= QB'(1) << (QB - 2);
                        r_cnt   <= CNT_W'(SB);
                        r_state <= S_ROOT;
                    end
                end
                // Digit-by-digit square root. The trial bit never overlaps
                // the partial root, so an OR forms their sum.
                S_ROOT: begin
                    if (alu_carry) begin
                        r_acc  <= alu_res;
                        r_root <= (r_root >> 1) | r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.std_value <= STD_BITS'(r_root);
                        r_out.std_ok    <= r_res_ok;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The fill count never runs past the window length.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_w)
        else $error("fill count exceeds window length");

    // Missing samples are a subset of the samples held.
    a_miss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= r_fill)
        else $error("missing count exceeds fill count");

    // The ring pointer stays inside the window.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_ptr) < r_w)
        else $error("ring pointer outside window");

    // An accepted sample keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("input not stalled after accepting a beat");

    // A result appears only when the sequencer finishes.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output valid without a finished computation");

endmodule
